// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NST_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/nst_pkg.sv
// Types, codes and the phase transition function of the session table.
// No dependencies.
package nst_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int KEY_BITS_DEF   = 64;
  localparam int KEY_W          = 64;

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_APPLY  = 3'd1;
  localparam logic [2:0] OP_QUERY  = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] EV_OFFER     = 3'd0;
  localparam logic [2:0] EV_AGREE     = 3'd1;
  localparam logic [2:0] EV_VERIFY    = 3'd2;
  localparam logic [2:0] EV_FINALIZE  = 3'd3;
  localparam logic [2:0] EV_TERMINATE = 3'd4;

  localparam logic [2:0] PH_INITIAL    = 3'd0;
  localparam logic [2:0] PH_REQUESTED  = 3'd1;
  localparam logic [2:0] PH_OFFERED    = 3'd2;
  localparam logic [2:0] PH_AGREED     = 3'd3;
  localparam logic [2:0] PH_VERIFIED   = 3'd4;
  localparam logic [2:0] PH_FINALIZED  = 3'd5;
  localparam logic [2:0] PH_TERMINATED = 3'd6;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_LIVE  = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [3:0]       slot_index;
    logic [2:0]       event_code;
    logic [KEY_W-1:0] consumer_key;
  } nst_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       result_slot;
    logic [2:0]       phase;
    logic [KEY_W-1:0] slot_consumer_key;
    logic [KEY_W-1:0] slot_provider_key;
    logic [4:0]       live_count;
  } nst_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CREATE,
    S_ACCESS,
    S_FIND
  } nst_state_t;

  function automatic logic [2:0] next_phase(input logic [2:0] ph, input logic [2:0] ev);
    logic [2:0] nph;
    nph = ph;
    if ((ph == PH_REQUESTED || ph == PH_OFFERED || ph == PH_AGREED ||
         ph == PH_VERIFIED) && ev == EV_TERMINATE) begin
      nph = PH_TERMINATED;
    end else begin
      case (ph)
        PH_REQUESTED: begin
          if (ev == EV_OFFER) nph = PH_OFFERED;
          else if (ev == EV_AGREE) nph = PH_AGREED;
        end
        PH_OFFERED: begin
          if (ev == EV_AGREE) nph = PH_AGREED;
        end
        PH_AGREED: begin
          if (ev == EV_VERIFY) nph = PH_VERIFIED;
        end
        PH_VERIFIED: begin
          if (ev == EV_FINALIZE) nph = PH_FINALIZED;
        end
        default: nph = ph;
      endcase
    end
    return nph;
  endfunction

endpackage

// File: rtl/negotiation_session_table.sv
// Negotiation session table, top level. Uses nst_pkg and assert_macros.svh.
// Slot phase, consumer key and provider key live in one synchronous RAM.
//
// One request is handled at a time. Query and apply event on a live slot go
// through accept, decode and RAM access; clear, unknown opcodes and query or
// apply event on a slot that is not live go through accept and decode only.
// Create walks the live bits from the lowest slot up to the first free one
// (to the last slot when full), and find walks the slots through the RAM read
// port up to the matching one (to the last slot on a miss): both walk the
// slots one per cycle. A new request is taken once the previous result sits
// in the output register. Live bits are flip-flops cleared by reset or
// clear-all, so no RAM clearing pass is needed.
`include "assert_macros.svh"

module negotiation_session_table #(
  parameter int SLOT_COUNT = nst_pkg::SLOT_COUNT_DEF,
  parameter int KEY_BITS   = nst_pkg::KEY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  nst_pkg::nst_req_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output nst_pkg::nst_rsp_t out_data,
  input  logic             cfg_we,
  input  logic [63:0]      cfg_wdata
);
  import nst_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int ENT_W  = 3 + 2 * KEY_BITS;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  nst_state_t            state_r, state_nxt;
  nst_req_t              req_r;
  logic [SLOT_W-1:0]     scan_r, scan_nxt;
  logic [SLOT_COUNT-1:0] live_r;
  logic [CNT_W-1:0]      live_total_r;
  logic [63:0]           prov_key_r;
  logic                  out_valid_r;
  nst_rsp_t              out_r;

  logic [ENT_W-1:0]      mem [SLOT_COUNT];
  logic [ENT_W-1:0]      mem_q;

  logic                  rd_en, wr_en;
  logic [SLOT_W-1:0]     rd_addr, wr_addr;
  logic [ENT_W-1:0]      wr_data;
  logic                  rsp_load, live_set, live_clr_all;
  nst_rsp_t              rsp;

  logic                  in_fire, out_free;
  logic [SLOT_W+3:0]     idx_x;
  logic [SLOT_W-1:0]     idx_slot;
  logic                  idx_live;
  logic [SLOT_W+3:0]     scan_x;
  logic [CNT_W+4:0]      cnt_cur_x, cnt_inc_x;
  logic [KEY_BITS-1:0]   req_key, prov_masked;
  logic [2:0]            ph_q, ph_new;
  logic [KEY_BITS-1:0]   ck_q, pk_q;
  logic                  find_hit;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Slot index field is 4 bits; the table may be smaller or larger.
  assign idx_x    = (SLOT_W + 4)'(req_r.slot_index);
  assign idx_slot = idx_x[SLOT_W-1:0];
  assign idx_live = (32'(req_r.slot_index) < SLOT_COUNT) && live_r[idx_slot];

  assign scan_x      = (SLOT_W + 4)'(scan_r);
  assign cnt_cur_x   = (CNT_W + 5)'(live_total_r);
  assign cnt_inc_x   = (CNT_W + 5)'(live_total_r) + (CNT_W + 5)'(1);
  assign req_key     = req_r.consumer_key[KEY_BITS-1:0];
  assign prov_masked = prov_key_r[KEY_BITS-1:0];

  assign ph_q   = mem_q[ENT_W-1 -: 3];
  assign ck_q   = mem_q[2*KEY_BITS-1 -: KEY_BITS];
  assign pk_q   = mem_q[KEY_BITS-1:0];
  assign ph_new = (req_r.opcode == OP_APPLY) ? next_phase(ph_q, req_r.event_code) : ph_q;
  assign find_hit = live_r[scan_r] && (ck_q == req_key);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (req_r.opcode)
          OP_CREATE: state_nxt = S_CREATE;
          OP_APPLY, OP_QUERY: begin
            if (idx_live) state_nxt = S_ACCESS;
            else if (rsp_load) state_nxt = S_IDLE;
          end
          OP_FIND: state_nxt = S_FIND;
          default: begin
            if (rsp_load) state_nxt = S_IDLE;
          end
        endcase
      end
      S_CREATE, S_ACCESS, S_FIND: begin
        if (rsp_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control and result
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = scan_r;
    wr_en        = 1'b0;
    wr_addr      = scan_r;
    wr_data      = '0;
    rsp_load     = 1'b0;
    live_set     = 1'b0;
    live_clr_all = 1'b0;
    scan_nxt     = scan_r;
    rsp          = '0;
    rsp.status     = STAT_OK;
    rsp.live_count = cnt_cur_x[4:0];
    case (state_r)
      S_IDLE: begin
        scan_nxt = '0;
      end
      S_DECODE: begin
        case (req_r.opcode)
          OP_CREATE: begin
            scan_nxt = '0;
          end
          OP_APPLY, OP_QUERY: begin
            if (idx_live) begin
              rd_en   = 1'b1;
              rd_addr = idx_slot;
            end else begin
              rsp_load        = out_free;
              rsp.status      = STAT_NOT_LIVE;
              rsp.result_slot = req_r.slot_index;
            end
          end
          OP_FIND: begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
          OP_CLEAR: begin
            rsp_load       = out_free;
            live_clr_all   = out_free;
            rsp.live_count = '0;
          end
          default: begin
            rsp_load = out_free;
          end
        endcase
      end
      S_CREATE: begin
        if (!live_r[scan_r]) begin
          rsp_load              = out_free;
          wr_en                 = out_free;
          live_set              = out_free;
          wr_addr               = scan_r;
          wr_data               = {PH_REQUESTED, req_key, prov_masked};
          rsp.result_slot       = scan_x[3:0];
          rsp.phase             = PH_REQUESTED;
          rsp.slot_consumer_key = KEY_W'(req_key);
          rsp.slot_provider_key = KEY_W'(prov_masked);
          rsp.live_count        = cnt_inc_x[4:0];
        end else if (scan_r == LAST_SLOT) begin
          rsp_load   = out_free;
          rsp.status = STAT_FULL;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_ACCESS: begin
        rsp_load              = out_free;
        wr_en                 = out_free && (req_r.opcode == OP_APPLY);
        wr_addr               = idx_slot;
        wr_data               = {ph_new, ck_q, pk_q};
        rsp.result_slot       = req_r.slot_index;
        rsp.phase             = ph_new;
        rsp.slot_consumer_key = KEY_W'(ck_q);
        rsp.slot_provider_key = KEY_W'(pk_q);
      end
      S_FIND: begin
        // mem_q holds the entry of scan_r; the read port only moves on a miss
        if (find_hit) begin
          rsp_load              = out_free;
          rsp.result_slot       = scan_x[3:0];
          rsp.phase             = ph_q;
          rsp.slot_consumer_key = KEY_W'(ck_q);
          rsp.slot_provider_key = KEY_W'(pk_q);
        end else if (scan_r == LAST_SLOT) begin
          rsp_load   = out_free;
          rsp.status = STAT_NOT_FOUND;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = scan_r + 1'b1;
          scan_nxt = scan_r + 1'b1;
        end
      end
      default: begin
        scan_nxt = '0;
      end
    endcase
  end

  // Entry RAM. Writes happen only in the last cycle of a request and reads
  // start in the decode cycle of the next one, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_r       <= '0;
      live_r       <= '0;
      live_total_r <= '0;
      prov_key_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
      if (cfg_we) prov_key_r <= cfg_wdata;
      if (live_clr_all) begin
        live_r       <= '0;
        live_total_r <= '0;
      end else if (live_set) begin
        live_r[scan_r] <= 1'b1;
        live_total_r   <= live_total_r + 1'b1;
      end
      if (rsp_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) req_r <= in_data;
    if (rsp_load) out_r <= rsp;
  end

  `NST_ASSERT_IMPL(a_live_count, 1'b1, live_total_r == CNT_W'($countones(live_r)), "live count off")
  `NST_ASSERT_NEXT(a_create_sets_live, live_set, live_r[$past(scan_r)], "created slot not live")
  `NST_ASSERT_IMPL(a_no_load_over_held, rsp_load, out_free, "result loaded over held result")
  `NST_ASSERT_NEXT(a_accept_decodes, in_fire, state_r == S_DECODE && !in_ready, "no decode")

endmodule
